// File: hdl/idt_pkg.sv
package idt_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int LEVEL_W         = 10;
    localparam int TAB_W           = 4;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = '1;
    localparam logic [TAB_W-1:0]   TAB_WIDTH_RST = 4'd4;

    typedef enum logic [1:0] {
        KIND_INDENT   = 2'd0,
        KIND_DEDENT   = 2'd1,
        KIND_END      = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_POP_RD,
        S_POP_CHK,
        S_POP_EMIT,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic       command;
        logic [7:0] leading_spaces;
        logic [5:0] leading_tabs;
        logic       line_is_blank;
        logic       inside_brackets;
    } t_in;

    typedef struct packed {
        t_kind token_kind;
        logic  last_of_run;
    } t_out;

endpackage

// File: hdl/idt_stack_ram.sv
module idt_stack_ram #(
    parameter int DEPTH = idt_pkg::STACK_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [idt_pkg::LEVEL_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [idt_pkg::LEVEL_W-1:0] o_rdata
);
    import idt_pkg::*;

    logic [LEVEL_W-1:0] r_mem [DEPTH];
    logic [LEVEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/indent_dedent_tracker_top.sv
// A line event is registered on acceptance and evaluated in S_EVAL, which loads its INDENT or OVERFLOW transfer.
// Each DEDENT of a line takes the steps stack memory read, top update, emit.
// End of input drains at one DEDENT per cycle while the output is not stalled, then END; no stack reads needed.
// A new event is taken only once the previous one has emitted its last result.
// Reset (sync, active low): one level (width zero), tab width 4, output empty;
// the stack memory itself is not cleared; entry 0 is never written, and its read data is never used.
module indent_dedent_tracker_top #(
    parameter int STACK_DEPTH = idt_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  idt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output idt_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [idt_pkg::TAB_W-1:0] i_cfg_wdata
);
    import idt_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count;
    logic [LEVEL_W-1:0] r_top;
    logic [LEVEL_W-1:0] r_width;
    logic [TAB_W-1:0]   r_tab_width;
    logic               r_out_valid;
    t_out               r_out_data;

    logic               w_acc, w_slot, w_full;
    logic               w_emit, w_last, w_we, w_re;
    t_kind              w_kind;
    logic [9:0]         w_prod;
    logic [10:0]        w_sum;
    logic [LEVEL_W-1:0] w_width;
    logic [LEVEL_W-1:0] w_rdata;
    logic [CW-1:0]      w_cnt_m2;

    assign w_acc  = i_in_valid && (r_state == S_IDLE);
    assign w_slot = !r_out_valid || !i_out_stall;
    assign w_full = (r_count == CNT_FULL);

    assign w_prod  = 10'(i_in_data.leading_tabs) * 10'(r_tab_width);
    assign w_sum   = 11'(i_in_data.leading_spaces) + 11'(w_prod);
    assign w_width = w_sum[10] ? LEVEL_MAX : w_sum[LEVEL_W-1:0];

    assign w_cnt_m2 = r_count - CW'(2);

    idt_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_width),
        .i_re    (w_re),
        .i_raddr (w_cnt_m2[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_in_data.command) begin
                        n_state = S_DRAIN;
                    end else if (!i_in_data.line_is_blank && !i_in_data.inside_brackets) begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (r_width > r_top) begin
                    if (w_slot) begin
                        n_state = S_IDLE;
                    end
                end else if (r_width < r_top) begin
                    n_state = S_POP_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_POP_RD:  n_state = S_POP_CHK;
            S_POP_CHK: n_state = S_POP_EMIT;
            S_POP_EMIT: begin
                if (w_slot) begin
                    n_state = (r_top > r_width) ? S_POP_RD : S_IDLE;
                end
            end
            S_DRAIN: begin
                if (w_slot && (r_count == CNT_ONE)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and actions
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_emit     = 1'b0;
        w_kind     = KIND_DEDENT;
        w_last     = 1'b0;
        w_we       = 1'b0;
        w_re       = 1'b0;
        unique case (r_state)
            S_IDLE: ;
            S_EVAL: begin
                if (r_width > r_top) begin
                    w_emit = w_slot;
                    w_last = 1'b1;
                    if (w_full) begin
                        w_kind = KIND_OVERFLOW;
                    end else begin
                        w_kind = KIND_INDENT;
                        w_we   = w_slot;
                    end
                end
            end
            S_POP_RD:  w_re = 1'b1;
            S_POP_CHK: ;
            S_POP_EMIT: begin
                w_emit = w_slot;
                w_last = !(r_top > r_width);
            end
            S_DRAIN: begin
                w_emit = w_slot;
                if (r_count == CNT_ONE) begin
                    w_kind = KIND_END;
                    w_last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_ONE;
            r_top       <= '0;
            r_tab_width <= TAB_WIDTH_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tab_width <= i_cfg_wdata;
            end
            unique case (r_state)
                S_EVAL: begin
                    if (w_we) begin
                        r_count <= r_count + CNT_ONE;
                        r_top   <= r_width;
                    end
                end
                S_POP_RD: r_count <= r_count - CNT_ONE;
                // bottom level is always zero and never lives in the memory
                S_POP_CHK: r_top <= (r_count == CNT_ONE) ? '0 : w_rdata;
                S_DRAIN: begin
                    if (w_slot) begin
                        if (r_count == CNT_ONE) begin
                            r_top <= '0;
                        end else begin
                            r_count <= r_count - CNT_ONE;
                        end
                    end
                end
                default: ;
            endcase
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_width <= w_width;
        end
        if (w_emit) begin
            r_out_data.token_kind  <= w_kind;
            r_out_data.last_of_run <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: hdl/idt_checker.sv
module idt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input idt_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input idt_pkg::t_out o_out_data
);
    import idt_pkg::*;

    // sync reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transfer changed");

    // only DEDENT can be followed by more tokens of the same event
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.token_kind != KIND_DEDENT) |-> o_out_data.last_of_run)
        else $error("non-DEDENT token not last of run");

    // a blank line produces nothing, block is ready again right away
    a_blank_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_in_data.command && i_in_data.line_is_blank
        |=> !o_in_stall)
        else $error("blank line kept the block busy");

endmodule

bind indent_dedent_tracker_top idt_checker u_idt_checker (.*);

// File: tb/tb_indent_dedent_tracker_top.sv
module tb_indent_dedent_tracker_top;
    timeunit 1ns;
    timeprecision 1ps;
    import idt_pkg::*;

    localparam int DEPTH          = STACK_DEPTH_DEF;
    localparam int WIDTH_CAP      = int'(LEVEL_MAX);
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LINES_PER_PHASE = 58;

    // Shadow of the indentation stack plus the queue of tokens still owed by the DUT.
    class indent_scoreboard;
        logic [LEVEL_W-1:0] levels [DEPTH];
        int                 depth;
        logic [TAB_W-1:0]   tab_w;
        t_out               pending [$];
        int                 errors;

        function new();
            depth     = 1;
            levels[0] = '0;
            tab_w     = TAB_WIDTH_RST;
            errors    = 0;
        endfunction

        function void push_token(t_kind kind, logic last);
            t_out tok;
            tok.token_kind  = kind;
            tok.last_of_run = last;
            pending.push_back(tok);
        endfunction

        function int line_width(t_in line);
            int w;
            w = int'(line.leading_spaces) + int'(line.leading_tabs) * int'(tab_w);
            if (w > WIDTH_CAP) begin
                w = WIDTH_CAP;
            end
            return w;
        endfunction

        function void note_line(t_in line);
            int w;
            int pops;
            int i;
            if (line.command) begin
                for (i = 1; i < depth; i++) begin
                    push_token(KIND_DEDENT, 1'b0);
                end
                push_token(KIND_END, 1'b1);
                depth = 1;
                levels[0] = '0;
                return;
            end
            if (line.inside_brackets || line.line_is_blank) begin
                return;
            end
            w = line_width(line);
            if (w > int'(levels[depth-1])) begin
                if (depth >= DEPTH) begin
                    push_token(KIND_OVERFLOW, 1'b1);
                end else begin
                    levels[depth] = w[LEVEL_W-1:0];
                    depth++;
                    push_token(KIND_INDENT, 1'b1);
                end
                return;
            end
            // narrower line: pop every deeper level, a width between levels just stops there
            pops = 0;
            while (depth > 1 && int'(levels[depth-1]) > w) begin
                depth--;
                pops++;
            end
            for (i = 0; i < pops; i++) begin
                push_token(KIND_DEDENT, i == pops - 1);
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_token(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected token kind %0d last %0d",
                                          got.token_kind, got.last_of_run));
                return;
            end
            want = pending.pop_front();
            if (got.token_kind !== want.token_kind) begin
                report_mismatch($sformatf("token_kind got %0d want %0d",
                                          got.token_kind, want.token_kind));
            end
            if (got.last_of_run !== want.last_of_run) begin
                report_mismatch($sformatf("last_of_run got %0d want %0d",
                                          got.last_of_run, want.last_of_run));
            end
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_in              in_data;
    logic             out_valid;
    logic             out_stall;
    t_out             out_data;
    logic             cfg_we;
    logic [TAB_W-1:0] cfg_wdata;

    bit               idle_en = 1'b1;
    int               quiet_cycles = 0;
    indent_scoreboard sb = new();

    indent_dedent_tracker_top #(
        .STACK_DEPTH (DEPTH)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                sb.check_token(out_data);
            end
            if (in_valid && !in_stall) begin
                sb.note_line(in_data);
            end
            if (cfg_we) begin
                sb.tab_w = cfg_wdata;
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_indent_dedent_tracker_top: errors");
                $finish;
            end
        end
    end

    initial begin : out_stall_gen
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (idle_en && $urandom_range(0, 6) == 0) begin
                hold = $urandom_range(1, 17);
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    function automatic t_in mk_line(logic cmd, int spaces, int tabs, logic blank,
                                    logic brackets);
        t_in line;
        line.command         = cmd;
        line.leading_spaces  = spaces[7:0];
        line.leading_tabs    = tabs[5:0];
        line.line_is_blank   = blank;
        line.inside_brackets = brackets;
        return line;
    endfunction

    // split a target width into spaces and tabs under the current tab width
    function automatic t_in encode_width(int target);
        t_in line;
        int  tw;
        int  tmin;
        int  tmax;
        int  tabs;
        tw = int'(sb.tab_w);
        if (tw == 0) begin
            return mk_line(1'b0, (target > 255) ? 255 : target, $urandom_range(0, 63),
                           1'b0, 1'b0);
        end
        tmax = target / tw;
        if (tmax > 63) begin
            tmax = 63;
        end
        tmin = (target > 255) ? (target - 255 + tw - 1) / tw : 0;
        if (tmin > tmax) begin
            line = mk_line(1'b0, 255, 63, 1'b0, 1'b0);
        end else begin
            tabs = $urandom_range(tmin, tmax);
            line = mk_line(1'b0, target - tabs * tw, tabs, 1'b0, 1'b0);
        end
        return line;
    endfunction

    function automatic t_in random_line();
        t_in                line;
        logic [31:0]        raw_word;
        logic [$bits(t_in)-1:0] raw;
        int                 r;
        int                 top;
        int                 target;
        r   = $urandom_range(0, 99);
        top = int'(sb.levels[sb.depth-1]);
        raw_word = $urandom;
        raw = raw_word[$bits(t_in)-1:0];
        if (r < 34) begin
            target = top + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 60)
                                                         : $urandom_range(1, 8));
            line = encode_width((target > WIDTH_CAP) ? WIDTH_CAP : target);
        end else if (r < 52) begin
            line = encode_width(int'(sb.levels[$urandom_range(0, sb.depth - 1)]));
        end else if (r < 60) begin
            line = encode_width($urandom_range(0, top));
        end else if (r < 66) begin
            line = encode_width(top);
        end else if (r < 74) begin
            line = raw;
            line.command = 1'b0;
            line.line_is_blank = 1'b1;
        end else if (r < 82) begin
            line = raw;
            line.command = 1'b0;
            line.inside_brackets = 1'b1;
        end else if (r < 85) begin
            line = raw;
            line.command = 1'b1;
        end else begin
            line = raw;
            if ($urandom_range(0, 3) != 0) begin
                line.command = 1'b0;
            end
        end
        return line;
    endfunction

    task automatic send_line(t_in line);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  = line;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // sender holds off until every owed token has come out, then lets the DUT settle
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_tab_width(logic [TAB_W-1:0] value);
        drain();
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // walk up one level at a time until the stack overflows, then close everything
    task automatic climb_to_overflow();
        int target;
        repeat (DEPTH + 1) begin
            target = int'(sb.levels[sb.depth-1]) + $urandom_range(1, 3);
            send_line(encode_width((target > WIDTH_CAP) ? WIDTH_CAP : target));
        end
        send_line(mk_line(1'b1, 0, 0, 1'b0, 1'b0));
    endtask

    task automatic random_phase(int lines, bit pause_midway);
        t_in line;
        int  sent;
        sent = 0;
        while (sent < lines) begin
            if ($urandom_range(0, 59) == 0) begin
                climb_to_overflow();
                sent += DEPTH + 2;
            end
            line = random_line();
            send_line(line);
            sent++;
            if (pause_midway && sent >= lines / 2) begin
                in_valid = 1'b0;
                while (sb.pending.size() != 0) @(negedge clk);
                pause_midway = 1'b0;
            end
        end
    endtask

    initial begin : stimulus
        logic [TAB_W-1:0] phase_tab [6];
        int               p;
        phase_tab = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4, 4'd0};
        phase_tab[5] = TAB_W'($urandom_range(1, 8));

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = TAB_WIDTH_RST;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        write_tab_width(TAB_WIDTH_RST);
        send_line(mk_line(1'b0, 0, 0, 1'b0, 1'b0));
        send_line(mk_line(1'b0, 4, 0, 1'b0, 1'b0));
        send_line(mk_line(1'b0, 0, 2, 1'b0, 1'b0));
        send_line(mk_line(1'b0, 255, 63, 1'b1, 1'b0));   // blank: ignored
        send_line(mk_line(1'b0, 255, 63, 1'b0, 1'b1));   // inside brackets: ignored
        send_line(mk_line(1'b0, 8, 0, 1'b0, 1'b0));      // same width
        send_line(mk_line(1'b0, 6, 0, 1'b0, 1'b0));      // between 4 and 8
        send_line(mk_line(1'b0, 2, 0, 1'b0, 1'b0));
        send_line(mk_line(1'b0, 255, 63, 1'b0, 1'b0));
        send_line(mk_line(1'b0, 0, 0, 1'b0, 1'b0));
        send_line(mk_line(1'b0, 4, 0, 1'b0, 1'b0));
        send_line(mk_line(1'b0, 4, 2, 1'b0, 1'b0));
        send_line(mk_line(1'b0, 1, 0, 1'b0, 1'b0));      // two pops, lands off-level
        send_line(mk_line(1'b0, 8, 0, 1'b0, 1'b0));
        send_line(mk_line(1'b1, 255, 63, 1'b1, 1'b1));   // end of input, fields ignored
        send_line(mk_line(1'b1, 0, 0, 1'b0, 1'b0));      // end with nothing open
        send_line(mk_line(1'b0, 0, 0, 1'b0, 1'b0));

        for (p = 0; p < 6; p++) begin
            write_tab_width(phase_tab[p]);
            if (p == 0) begin
                climb_to_overflow();
            end
            if (p == 2) begin
                send_line(mk_line(1'b0, 0, 63, 1'b0, 1'b0));  // tabs count for nothing
                send_line(mk_line(1'b0, 3, 63, 1'b0, 1'b0));
            end
            if (p == 3) begin
                send_line(mk_line(1'b0, 255, 63, 1'b0, 1'b0));  // saturates
                send_line(mk_line(1'b0, 200, 63, 1'b0, 1'b0));
                send_line(mk_line(1'b0, 255, 0, 1'b0, 1'b0));
                send_line(mk_line(1'b1, 0, 0, 1'b0, 1'b0));
            end
            if (p == 5) begin
                idle_en = 1'b0;
            end
            random_phase(LINES_PER_PHASE, p == 1);
        end

        drain();
        while (sb.pending.size() != 0) begin
            void'(sb.pending.pop_front());
            sb.report_mismatch("expected token never arrived");
        end
        if (sb.errors == 0) begin
            $display("tb_indent_dedent_tracker_top: clean");
        end else begin
            $display("tb_indent_dedent_tracker_top: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/idt_pkg.sv
hdl/idt_stack_ram.sv
hdl/indent_dedent_tracker_top.sv
hdl/idt_checker.sv
tb/tb_indent_dedent_tracker_top.sv
